// ===== hdl/cirx_pkg.sv =====
`default_nettype none

package cirx_pkg;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 64;
  localparam int unsigned NUM_CHARS = 16;

  // register index, taken from paddr[4:3]
  localparam logic [1:0] REG_BASE_LEN    = 2'd0;
  localparam logic [1:0] REG_DIGITS_LOW  = 2'd1;
  localparam logic [1:0] REG_DIGITS_HIGH = 2'd2;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_LO    = 8'd32;
  localparam logic [7:0] CH_HI    = 8'd126;
  localparam logic [7:0] CH_NONE  = 8'd0;

  typedef logic [NUM_CHARS-1:0][7:0] alpha_t;

  typedef struct packed {
    logic        bad;
    logic        neg;
    logic [31:0] mag;
  } cirx_item_t;

  // floor(2^32 / d); the product's upper word is the quotient or one short of it
  function automatic logic [31:0] recip_of(input logic [4:0] d);
    logic [31:0] r;
    unique case (d)
      5'd2:    r = 32'h8000_0000;
      5'd3:    r = 32'h5555_5555;
      5'd4:    r = 32'h4000_0000;
      5'd5:    r = 32'h3333_3333;
      5'd6:    r = 32'h2AAA_AAAA;
      5'd7:    r = 32'h2492_4924;
      5'd8:    r = 32'h2000_0000;
      5'd9:    r = 32'h1C71_C71C;
      5'd10:   r = 32'h1999_9999;
      5'd11:   r = 32'h1745_D174;
      5'd12:   r = 32'h1555_5555;
      5'd13:   r = 32'h13B1_3B13;
      5'd14:   r = 32'h1249_2492;
      5'd15:   r = 32'h1111_1111;
      5'd16:   r = 32'h1000_0000;
      default: r = 32'h0000_0000;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/cirx_regs.sv =====
`default_nettype none

module cirx_regs
  import cirx_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output logic      [4:0]        base_len_o,
  output alpha_t                 alpha_o,
  output logic                   bad_o
);

  logic [4:0]  base_len_q;
  logic [63:0] digits_low_q;
  logic [63:0] digits_high_q;
  logic        bad_q;
  logic        bad_d;
  logic        wr_en;
  logic [1:0]  reg_idx;
  alpha_t      alpha;
  logic [7:0]  ch;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:3];
  assign alpha   = {digits_high_q, digits_low_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_len_q    <= '0;
      digits_low_q  <= '0;
      digits_high_q <= '0;
      bad_q         <= 1'b1;
    end else begin
      bad_q <= bad_d;
      if (wr_en) begin
        unique case (reg_idx)
          REG_BASE_LEN:    base_len_q    <= pwdata[4:0];
          REG_DIGITS_LOW:  digits_low_q  <= pwdata;
          REG_DIGITS_HIGH: digits_high_q <= pwdata;
          default:         ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BASE_LEN:    prdata = {59'd0, base_len_q};
      REG_DIGITS_LOW:  prdata = digits_low_q;
      REG_DIGITS_HIGH: prdata = digits_high_q;
      default:         prdata = '0;
    endcase
  end

  // flag the alphabet: radix out of range, sign or unprintable char, repeats
  always_comb begin
    ch    = '0;
    bad_d = (base_len_q <= 5'd1) || (base_len_q > 5'(MAX_DIGITS));
    for (int i = 0; i < NUM_CHARS; i++) begin
      if (5'(i) < base_len_q) begin
        ch = alpha[i];
        if (ch == CH_MINUS || ch == CH_PLUS || ch < CH_LO || ch > CH_HI) begin
          bad_d = 1'b1;
        end
        for (int j = i + 1; j < NUM_CHARS; j++) begin
          if (5'(j) < base_len_q && alpha[j] == ch) begin
            bad_d = 1'b1;
          end
        end
      end
    end
  end

  assign base_len_o = base_len_q;
  assign alpha_o    = alpha;
  assign bad_o      = bad_q;

endmodule

`default_nettype wire

// ===== hdl/cirx_front.sv =====
`default_nettype none

module cirx_front
  import cirx_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [31:0] value_i,
  input  wire logic               bad_i,
  output logic                    push_o,
  output cirx_item_t              item_o,
  input  wire logic               full_i
);

  logic        hold_q;
  logic        hold_d;
  logic [31:0] value_q;
  logic        accept;

  assign in_stall_o = hold_q & full_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign push_o     = hold_q & ~full_i;

  always_comb begin
    hold_d = hold_q;
    if (accept) begin
      hold_d = 1'b1;
    end else if (push_o) begin
      hold_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
    end else begin
      hold_q <= hold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      value_q <= $unsigned(value_i);
    end
  end

  // split sign and magnitude; the most negative value wraps to 2^31 exactly
  always_comb begin
    item_o.bad = bad_i;
    item_o.neg = value_q[31];
    item_o.mag = value_q[31] ? (32'd0 - value_q) : value_q;
  end

endmodule

`default_nettype wire

// ===== hdl/cirx_fifo.sv =====
`default_nettype none

module cirx_fifo
  import cirx_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire cirx_item_t item_i,
  output logic            full_o,
  input  wire logic       pop_i,
  output cirx_item_t      item_o,
  output logic            empty_o
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cirx_item_t     mem_q [DEPTH];
  logic [PW-1:0]  wr_q;
  logic [PW-1:0]  rd_q;
  logic [CW-1:0]  count_q;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== hdl/cirx_back.sv =====
`default_nettype none

module cirx_back
  import cirx_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cirx_item_t item_i,
  input  wire logic       empty_i,
  output logic            pop_o,
  input  wire logic [4:0] radix_i,
  input  wire alpha_t     alpha_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_char_o,
  output logic            bad_alphabet_o,
  output logic            last_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_FIX,
    ST_SIGN,
    ST_DIGIT
  } cvt_state_e;

  cvt_state_e  state_q;
  logic [31:0] mag_q;
  logic        neg_q;
  logic [31:0] recip_q;
  logic [63:0] prod_q;
  logic [5:0]  cnt_q;
  logic [3:0]  dig_mem_q [32];
  logic        out_valid_q;
  logic [7:0]  out_char_q;
  logic        out_bad_q;
  logic        out_last_q;

  logic        slot_free;
  logic        emit;
  logic [31:0] q_est;
  logic [5:0]  qd_low;
  logic [5:0]  rem6;
  logic        fix;
  logic [5:0]  rem_fixed;
  logic [3:0]  digit;
  logic [31:0] quot;
  logic [4:0]  rd_idx;

  assign slot_free = ~out_valid_q | ~out_stall_i;
  assign pop_o     = (state_q == ST_IDLE) & ~empty_i & (~item_i.bad | slot_free);
  assign emit      = slot_free & (((state_q == ST_IDLE) & ~empty_i & item_i.bad) |
                                  (state_q == ST_SIGN) | (state_q == ST_DIGIT));

  // remainder from the estimated quotient; it is below twice the radix,
  // so six low bits carry it
  assign q_est     = prod_q[63:32];
  assign qd_low    = 6'(11'(q_est[5:0]) * 11'(radix_i));
  assign rem6      = mag_q[5:0] - qd_low;
  assign fix       = (rem6 >= {1'b0, radix_i});
  assign rem_fixed = fix ? (rem6 - {1'b0, radix_i}) : rem6;
  assign digit     = rem_fixed[3:0];
  assign quot      = q_est + 32'(fix);
  assign rd_idx    = 5'(cnt_q - 6'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mag_q       <= '0;
      neg_q       <= 1'b0;
      recip_q     <= '0;
      prod_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      out_bad_q   <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (!empty_i) begin
            if (item_i.bad) begin
              if (slot_free) begin
                out_char_q  <= CH_NONE;
                out_bad_q   <= 1'b1;
                out_last_q  <= 1'b1;
              end
            end else begin
              mag_q   <= item_i.mag;
              neg_q   <= item_i.neg;
              recip_q <= recip_of(radix_i);
              cnt_q   <= '0;
              state_q <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          prod_q  <= 64'(mag_q) * 64'(recip_q);
          state_q <= ST_FIX;
        end
        ST_FIX: begin
          mag_q <= quot;
          cnt_q <= cnt_q + 6'd1;
          if (quot == '0) begin
            state_q <= neg_q ? ST_SIGN : ST_DIGIT;
          end else begin
            state_q <= ST_MUL;
          end
        end
        ST_SIGN: begin
          if (slot_free) begin
            out_char_q  <= CH_MINUS;
            out_bad_q   <= 1'b0;
            out_last_q  <= 1'b0;
            state_q     <= ST_DIGIT;
          end
        end
        ST_DIGIT: begin
          // emit most significant first: read the stored digits backward
          if (slot_free) begin
            out_char_q  <= alpha_i[dig_mem_q[rd_idx]];
            out_bad_q   <= 1'b0;
            out_last_q  <= (cnt_q == 6'd1);
            cnt_q       <= cnt_q - 6'd1;
            if (cnt_q == 6'd1) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FIX) begin
      dig_mem_q[cnt_q[4:0]] <= digit;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_char_o     = out_char_q;
  assign bad_alphabet_o = out_bad_q;
  assign last_o         = out_last_q;

  a_digit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIX) |-> ({2'b00, digit} < {1'b0, radix_i}))
    else $error("reciprocal correction left remainder not below radix");

  a_bad_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_bad_q) |-> out_last_q)
    else $error("alphabet error result not flagged last");

  a_digit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIGIT) |-> (cnt_q != 6'd0 && cnt_q <= 6'd32))
    else $error("digit count out of range while emitting");

endmodule

`default_nettype wire

// ===== hdl/integer_to_custom_radix_digits.sv =====
`default_nettype none

// Converts each signed 32-bit value on the input channel to characters in the
// radix given by the configured alphabet (base_len characters from
// digits_low/digits_high). A negative value first gives a '-' transfer, then
// the digits, most significant first, with last set on the final one. An
// alphabet that is too short, longer than MAX_DIGITS, holds a sign, an
// unprintable byte or a repeated character gives a single transfer with
// bad_alphabet and last set. An input register and a two-entry queue sit in
// front of the converter, so up to three values can be taken while it works.
// The converter handles one value at a time: it picks the value up, steps
// each digit through the reciprocal multiplier (multiply, then remainder
// correction) and then emits each character through the single output
// register, holding while the output is stalled. An alphabet error is
// answered straight from the idle state, without the multiplier. The alphabet
// check is registered, so let it update after the last configuration write
// before sending values.
module integer_to_custom_radix_digits
  import cirx_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [ADDR_W-1:0]  paddr,
  input  wire logic [DATA_W-1:0]  pwdata,
  output logic      [DATA_W-1:0]  prdata,
  output logic                    pready,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [31:0] value_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic      [7:0]         out_char_o,
  output logic                    bad_alphabet_o,
  output logic                    last_o
);

  logic       [4:0] base_len;
  alpha_t           alpha;
  logic             bad;
  logic             push;
  logic             full;
  logic             pop;
  logic             empty;
  cirx_item_t       front_item;
  cirx_item_t       queue_item;

  cirx_regs #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .base_len_o (base_len),
    .alpha_o    (alpha),
    .bad_o      (bad)
  );

  cirx_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .value_i    (value_i),
    .bad_i      (bad),
    .push_o     (push),
    .item_o     (front_item),
    .full_i     (full)
  );

  cirx_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (queue_item),
    .empty_o (empty)
  );

  cirx_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (queue_item),
    .empty_i        (empty),
    .pop_o          (pop),
    .radix_i        (base_len),
    .alpha_i        (alpha),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_char_o     (out_char_o),
    .bad_alphabet_o (bad_alphabet_o),
    .last_o         (last_o)
  );

endmodule

`default_nettype wire

// ===== tb/integer_to_custom_radix_digits_tb.sv =====
module integer_to_custom_radix_digits_tb;
  import cirx_pkg::*;

  localparam int MAX_DIGITS = 16;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 120;

  class radix_scoreboard;
    typedef struct {
      logic [7:0] ch;
      logic       bad;
      logic       last;
    } char_t;

    char_t       expected_chars[$];
    logic [4:0]  radix;
    logic [63:0] chars_low;
    logic [63:0] chars_high;
    int          mismatches;

    function new();
      radix = '0;
      chars_low = '0;
      chars_high = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [63:0] data);
      case (idx)
        REG_BASE_LEN:    radix = data[4:0];
        REG_DIGITS_LOW:  chars_low = data;
        REG_DIGITS_HIGH: chars_high = data;
        default: ;
      endcase
    endfunction

    function logic [7:0] char_at(int k);
      logic [63:0] w;
      w = (k < 8) ? chars_low : chars_high;
      return w[(k % 8) * 8 +: 8];
    endfunction

    function bit alphabet_bad();
      logic [7:0] c;
      if (radix <= 1 || radix > MAX_DIGITS) return 1'b1;
      for (int i = 0; i < radix; i++) begin
        c = char_at(i);
        if (c == CH_MINUS || c == CH_PLUS || c < CH_LO || c > CH_HI) return 1'b1;
        for (int j = i + 1; j < radix; j++) begin
          if (char_at(j) == c) return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void queue_char(logic [7:0] ch, logic bad, logic last);
      char_t e;
      e.ch = ch;
      e.bad = bad;
      e.last = last;
      expected_chars.push_back(e);
    endfunction

    // Work out the characters one accepted value turns into.
    function void note_value(logic [31:0] v);
      logic [31:0] mag;
      int unsigned digits[$];
      if (alphabet_bad()) begin
        queue_char(CH_NONE, 1'b1, 1'b1);
        return;
      end
      mag = v;
      if (v[31]) begin
        queue_char(CH_MINUS, 1'b0, 1'b0);
        mag = -v;
      end
      do begin
        digits.push_front(mag % radix);
        mag = mag / radix;
      end while (mag != 0 && digits.size() < 32);
      for (int i = 0; i < digits.size(); i++) begin
        queue_char(char_at(digits[i]), 1'b0, i == digits.size() - 1);
      end
    endfunction

    function void check_char(logic [7:0] ch, logic bad, logic last);
      char_t e;
      if (expected_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected transfer char=%h bad=%b last=%b", ch, bad, last);
        return;
      end
      e = expected_chars.pop_front();
      if (ch !== e.ch || bad !== e.bad || last !== e.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: char exp %h got %h, bad exp %b got %b, last exp %b got %b",
                   e.ch, ch, e.bad, bad, e.last, last);
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic signed [31:0]  value_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [7:0]          out_char_o;
  logic                bad_alphabet_o;
  logic                last_o;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycle_count = 0;

  radix_scoreboard board = new();

  integer_to_custom_radix_digits #(
    .MAX_DIGITS(MAX_DIGITS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_char_o     (out_char_o),
    .bad_alphabet_o (bad_alphabet_o),
    .last_o         (last_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Check each character transfer, then draw the next stall.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_char(out_char_o, bad_alphabet_o, last_o);
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Leaves valid high after the transfer; the next call or drain decides.
  task automatic send_value(logic [31:0] v);
    int gap;
    gap = 0;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i <= v;
    do @(posedge clk_i); while (in_stall_o);
    board.note_value(v);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // Hold psel across back-to-back writes; the caller drops it.
  task automatic reg_write(logic [1:0] idx, logic [63:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    board.write_reg(idx, data);
  endtask

  task automatic load_alphabet(logic [4:0] n, logic [63:0] lo, logic [63:0] hi);
    drain();
    reg_write(REG_BASE_LEN, {59'd0, n});
    reg_write(REG_DIGITS_LOW, lo);
    reg_write(REG_DIGITS_HIGH, hi);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    // the alphabet check is registered
    repeat (2) @(posedge clk_i);
  endtask

  function automatic logic [63:0] pack8(string s, int first, logic [7:0] fill);
    logic [63:0] w;
    for (int k = 0; k < 8; k++) begin
      w[k*8 +: 8] = (first + k < s.len()) ? s[first + k] : fill;
    end
    return w;
  endfunction

  task automatic load_text(string s, logic [7:0] fill);
    load_alphabet(5'(s.len()), pack8(s, 0, fill), pack8(s, 8, fill));
  endtask

  task automatic random_alphabet();
    logic [7:0]  chars [16];
    bit [127:0]  used;
    logic [7:0]  c;
    logic [63:0] lo;
    logic [63:0] hi;
    int          n;
    // raw register contents: mostly bad alphabets, every bit toggles
    if ($urandom_range(4) == 0) begin
      load_alphabet(5'($urandom_range(31)), {$urandom, $urandom}, {$urandom, $urandom});
      return;
    end
    case ($urandom_range(3))
      0:       n = 2;
      1:       n = 16;
      default: n = $urandom_range(16, 2);
    endcase
    for (int k = 0; k < 16; k++) chars[k] = 8'($urandom_range(255));
    used = '0;
    for (int k = 0; k < n; k++) begin
      do c = 8'($urandom_range(126, 32));
      while (used[c] || c == CH_MINUS || c == CH_PLUS);
      used[c] = 1'b1;
      chars[k] = c;
    end
    for (int k = 0; k < 8; k++) begin
      lo[k*8 +: 8] = chars[k];
      hi[k*8 +: 8] = chars[k + 8];
    end
    load_alphabet(5'(n), lo, hi);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(3))
          0:       return 32'h0000_0000;
          1:       return 32'hFFFF_FFFF;
          2:       return 32'h7FFF_FFFF;
          default: return 32'h8000_0000;
        endcase
      end
      1, 2:    return 32'($urandom_range(80)) - 32'd40;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] dec_vals [8] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'd9, 32'd10,
                                  32'hFFFF_FFF6, 32'h7FFF_FFFF, 32'h8000_0000};
    logic [31:0] bin_vals [4] = '{32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
    logic [31:0] wide_vals [4] = '{32'h8000_0000, 32'd15, 32'd16, 32'hFFFF_FFF0};
    logic [63:0] lo;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty alphabet straight out of reset
    send_value(32'd12345);

    // unused bytes hold signs, which must not matter
    load_text("0123456789", CH_MINUS);
    foreach (dec_vals[i]) send_value(dec_vals[i]);

    load_text("01", CH_PLUS);
    foreach (bin_vals[i]) send_value(bin_vals[i]);

    // printable range ends: space and tilde
    load_text(" ~!\"#$%&'()*,./0", 8'h00);
    foreach (wide_vals[i]) send_value(wide_vals[i]);

    // bad alphabets, one value each
    load_text("7", 8'h00);
    send_value($urandom);
    load_alphabet(5'd17, pack8("0123456789ABCDEF", 0, 8'h00),
                  pack8("0123456789ABCDEF", 8, 8'h00));
    send_value($urandom);
    load_text("01+3", 8'h00);
    send_value($urandom);
    load_text("0-12", 8'h00);
    send_value($urandom);
    lo = pack8("0123", 0, 8'h00);
    lo[15:8] = 8'd31;
    load_alphabet(5'd4, lo, '0);
    send_value($urandom);
    lo = pack8("0123", 0, 8'h00);
    lo[31:24] = 8'd127;
    load_alphabet(5'd4, lo, '0);
    send_value($urandom);
    load_alphabet(5'd16, '1, '1);
    send_value($urandom);
    load_text("abcdefghia", 8'h00);
    send_value($urandom);

    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      for (int seg = 0; seg < 4; seg++) begin
        random_alphabet();
        for (int i = 0; i < 24; i++) begin
          // hold off until the converter has emptied
          if (seg == 1 && i == 12) drain();
          send_value(rand_value());
        end
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/cirx_pkg.sv
hdl/cirx_regs.sv
hdl/cirx_front.sv
hdl/cirx_fifo.sv
hdl/cirx_back.sv
hdl/integer_to_custom_radix_digits.sv
tb/integer_to_custom_radix_digits_tb.sv
